/* hdl/escf_pkg.sv */
`timescale 1ns / 1ps
// escf_pkg: constants, register indexes and crc helper for the escape framer
// no dependencies

package escf_pkg;

    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_XOR    = 8'h20;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam logic        START_ENABLE_RST = 1'b1;
    localparam logic [7:0]  START_CHAR_RST   = 8'h7E;
    localparam logic [7:0]  END_CHAR_RST     = 8'h7E;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
    localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [1:0] {
        CFG_START_ENABLE = 2'd0,
        CFG_START_CHAR   = 2'd1,
        CFG_END_CHAR     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } slot_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

    function automatic logic needs_escape(input logic [7:0] data);
        return (data == ESC_BYTE) || (data == FLAG_BYTE);
    endfunction

endpackage

/* hdl/escf_if.sv */
`timescale 1ns / 1ps
// escf_in_if / escf_out_if: valid/ready channels of the escape framer
// no dependencies

interface escf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface escf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, output out_byte, output frame_end, input ready);
    modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

/* hdl/escape_framer_crc16_unit.sv */
`timescale 1ns / 1ps
// escape_framer_crc16_unit: byte framer with 0x7d/0x7e escaping and crc-16/x-25
// depends on escf_pkg and escf_if
//
//  channel   | dir | payload                 | handshake
//  ----------+-----+-------------------------+-------------
//  in_ch     | in  | data_byte, last_byte    | valid/ready
//  out_ch    | out | out_byte, frame_end     | valid/ready
//  cfg       | in  | cfg_index, cfg_data     | cfg_we only
//
// an accepted byte expands into a registered slot buffer of 1 to 8 output bytes
// the buffer drains one byte per cycle while out_ch.ready is high
// one input byte makes 1 to 8 output bytes, typically 1 or 2 inside a frame
// the next byte is taken in the cycle the buffer's final byte leaves
// reset clears crc, frame state, buffer count and config; no clearing pass

module escape_framer_crc16_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    escf_in_if.sink               in_ch,
    escf_out_if.source            out_ch
);

    logic        start_enable_reg;
    logic [7:0]  start_char_reg;
    logic [7:0]  end_char_reg;
    logic [15:0] crc_reg;
    logic        in_frame_reg;

    escf_pkg::slot_t                      slot_reg [escf_pkg::SLOT_COUNT];
    escf_pkg::slot_t                      slot_next [escf_pkg::SLOT_COUNT];
    logic [escf_pkg::SLOT_CNT_W-1:0]      left_reg;
    logic [escf_pkg::SLOT_IDX_W-1:0]      rd_ptr_reg;

    logic [escf_pkg::SLOT_CNT_W-1:0]      fill_cnt;
    logic [15:0]                          crc_next;
    logic [15:0]                          fcs;
    logic                                 in_take;
    logic                                 out_take;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_enable_reg <= escf_pkg::START_ENABLE_RST;
            start_char_reg   <= escf_pkg::START_CHAR_RST;
            end_char_reg     <= escf_pkg::END_CHAR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                escf_pkg::CFG_START_ENABLE: start_enable_reg <= cfg_data[0];
                escf_pkg::CFG_START_CHAR:   start_char_reg   <= cfg_data;
                escf_pkg::CFG_END_CHAR:     end_char_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ch.ready = (left_reg == '0) ||
                         ((left_reg == escf_pkg::SLOT_CNT_W'(1)) && out_ch.ready);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign out_take    = out_ch.valid && out_ch.ready;

    assign crc_next = escf_pkg::crc_update(crc_reg, in_ch.data_byte);
    assign fcs      = ~crc_next;

    // expand one transaction into its output byte sequence
    always_comb
    begin
        logic [escf_pkg::SLOT_CNT_W-1:0] n;
        logic [7:0]                      b;
        n = '0;
        for (int i = 0; i < escf_pkg::SLOT_COUNT; i++)
            slot_next[i] = '0;

        if (!in_frame_reg && start_enable_reg)
        begin
            slot_next[n[escf_pkg::SLOT_IDX_W-1:0]] = '{start_char_reg, 1'b0};
            n = n + 1'b1;
        end

        for (int j = 0; j < 3; j++)
        begin
            if (j == 0)
                b = in_ch.data_byte;
            else if (j == 1)
                b = fcs[7:0];
            else
                b = fcs[15:8];
            if ((j == 0) || in_ch.last_byte)
            begin
                if (escf_pkg::needs_escape(b))
                begin
                    slot_next[n[escf_pkg::SLOT_IDX_W-1:0]] = '{escf_pkg::ESC_BYTE, 1'b0};
                    n = n + 1'b1;
                    slot_next[n[escf_pkg::SLOT_IDX_W-1:0]] = '{b ^ escf_pkg::ESC_XOR, 1'b0};
                    n = n + 1'b1;
                end
                else
                begin
                    slot_next[n[escf_pkg::SLOT_IDX_W-1:0]] = '{b, 1'b0};
                    n = n + 1'b1;
                end
            end
        end

        if (in_ch.last_byte)
        begin
            slot_next[n[escf_pkg::SLOT_IDX_W-1:0]] = '{end_char_reg, 1'b1};
            n = n + 1'b1;
        end
        fill_cnt = n;
    end

    // frame state and drain control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= escf_pkg::CRC_INIT;
            in_frame_reg <= 1'b0;
            left_reg     <= '0;
            rd_ptr_reg   <= '0;
        end
        else if (in_take)
        begin
            crc_reg      <= in_ch.last_byte ? escf_pkg::CRC_INIT : crc_next;
            in_frame_reg <= !in_ch.last_byte;
            left_reg     <= fill_cnt;
            rd_ptr_reg   <= '0;
        end
        else if (out_take)
        begin
            left_reg   <= left_reg - 1'b1;
            rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            slot_reg <= slot_next;
    end

    assign out_ch.valid     = (left_reg != '0);
    assign out_ch.out_byte  = slot_reg[rd_ptr_reg].out_byte;
    assign out_ch.frame_end = slot_reg[rd_ptr_reg].frame_end;

endmodule

/* hdl/escf_checker.sv */
`timescale 1ns / 1ps
// escf_checker: port-level checks for escape_framer_crc16_unit, with its bind
// depends on escape_framer_crc16_unit and escf_if

module escf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       frame_end
);

    // a stalled output transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
        else $error("stalled output changed");

    // every accepted byte yields output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted byte produced no output");

    // input only opens while output is idle or its final byte leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_ready)
        else $error("input ready while output stalled");

    // the end byte is always the final byte of its sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && frame_end |-> in_ready)
        else $error("end byte not final");

    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid in reset");

endmodule

bind escape_framer_crc16_unit escf_checker u_escf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .frame_end (out_ch.frame_end)
);
